// ===== sv/tss_pkg.sv =====
// Package for the timed sampling sequencer: types, codes and constants.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tss_pkg;

    // Field widths
    localparam int unsigned MINUTE_W = 27;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned LOOP_W   = 8;
    localparam int unsigned DAYREM_W = 11;
    localparam int unsigned CFG_W    = 27;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 48;

    // Minutes in one day, and the retry count above which the alarm sounds
    localparam int unsigned MIN_PER_DAY = 1440;
    localparam int unsigned ALARM_AFTER = 10;

    // Division of a 27-bit minute by 1440: (s >> 5) / 45 by reciprocal
    localparam int unsigned       DAY_SHIFT_W = 22;
    localparam logic [22:0]       DAY_RECIP   = 23'd5965233;
    localparam int unsigned       DAY_RSHIFT  = 28;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_MINUTE    = 3'd0,
        CFG_DELAY_MINUTES   = 3'd1,
        CFG_DELAY_MODE      = 3'd2,
        CFG_SAMPLE_MINUTES  = 3'd3,
        CFG_SUSPEND_MINUTES = 3'd4,
        CFG_LOOP_COUNT      = 3'd5,
        CFG_SAMPLE_MODE     = 3'd6,
        CFG_PRESSURE_LIMIT  = 3'd7
    } t_cfg_idx;

    // Sequencer phase
    typedef enum logic [1:0] {
        PH_INIT   = 2'd0,
        PH_WAIT   = 2'd1,
        PH_SAMPLE = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    // Reported run state
    typedef enum logic [2:0] {
        ST_SUSPEND = 3'd0,
        ST_PAUSE   = 3'd1,
        ST_SAMPLE  = 3'd2,
        ST_ERROR   = 3'd3,
        ST_FINISH  = 3'd4
    } t_run_state;

    typedef struct packed {
        logic [MINUTE_W-1:0] start_minute;
        logic [COUNT_W-1:0]  delay_minutes;
        logic                delay_mode;
        logic [COUNT_W-1:0]  sample_minutes;
        logic [COUNT_W-1:0]  suspend_minutes;
        logic [LOOP_W-1:0]   loop_count;
        logic                sample_mode;
        logic [COUNT_W-1:0]  pressure_limit;
    } t_cfg;

    typedef struct packed {
        logic [MINUTE_W-1:0]       now_minute;
        logic                      clean_request;
        logic                      pause_request;
        logic                      fatal_request;
        logic signed [COUNT_W-1:0] pressure;
    } t_item;

    typedef struct packed {
        logic                pump_on;
        t_run_state          run_state;
        logic [COUNT_W-1:0]  remaining_minutes;
        logic [LOOP_W-1:0]   loop_number;
        logic [COUNT_W-1:0]  sampled_minutes;
        logic                alarm_beep;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/tss_day_rem.sv =====
// Minute-of-day unit: registered remainder of the task start minute by 1440.
// Two register stages, reciprocal multiply then constant multiply; uses tss_pkg.
`default_nettype none

module tss_day_rem (
    input  wire logic                           i_clk,
    input  wire logic [tss_pkg::MINUTE_W-1:0]   i_minute,
    output logic      [tss_pkg::DAYREM_W-1:0]   o_day_rem
);
    import tss_pkg::*;

    localparam int unsigned PROD_W = DAY_SHIFT_W + 23;
    localparam int unsigned QUO_W  = PROD_W - DAY_RSHIFT;

    logic [PROD_W-1:0]   r_prod;
    logic [MINUTE_W-1:0] r_minute;
    logic [QUO_W-1:0]    w_quo;
    logic [MINUTE_W-1:0] w_rem;

    // Stage one: quotient estimate of (minute / 32) / 45, exact for 22 bits
    always_ff @(posedge i_clk) begin
        r_prod   <= PROD_W'(i_minute[MINUTE_W-1:5]) * PROD_W'(DAY_RECIP);
        r_minute <= i_minute;
    end

    assign w_quo = r_prod[PROD_W-1:DAY_RSHIFT];
    assign w_rem = r_minute - MINUTE_W'(MINUTE_W'(w_quo) * MINUTE_W'(MIN_PER_DAY));

    // Stage two: remainder
    always_ff @(posedge i_clk) begin
        o_day_rem <= w_rem[DAYREM_W-1:0];
    end

endmodule

`default_nettype wire

// ===== sv/tss_core.sv =====
// Sequencer core: phase state, run timing, pressure protection and minute count.
// One loop step per cycle on the held item while the top level lets steps through; uses tss_pkg.
`default_nettype none

module tss_core #(
    parameter int unsigned RETRY_LIMIT = 15
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tss_pkg::t_cfg                 i_cfg,
    input  wire logic [tss_pkg::DAYREM_W-1:0]  i_day_rem,
    input  wire tss_pkg::t_item                i_item,
    input  wire logic                          i_valid,
    input  wire logic                          i_go,
    output logic                               o_ret,
    output tss_pkg::t_result                   o_res
);
    import tss_pkg::*;

    localparam int unsigned RETRY_W = $clog2(RETRY_LIMIT + 1);
    localparam logic [RETRY_W-1:0] RETRY_MAX = RETRY_W'(RETRY_LIMIT);

    t_phase              r_phase, n_phase;
    logic [MINUTE_W-1:0] r_start_time, n_start_time;
    logic [LOOP_W-1:0]   r_loop, n_loop;
    logic [COUNT_W-1:0]  r_mp, n_mp;
    logic [RETRY_W-1:0]  r_retry, n_retry;
    logic                r_fatal, n_fatal;
    logic [MINUTE_W-1:0] r_last, n_last;

    logic [MINUTE_W-1:0] w_now;
    logic [MINUTE_W-1:0] w_init_start;
    logic                w_wrap_day;
    logic                w_in_wait;
    logic                w_due;
    logic                w_quit;
    logic [MINUTE_W:0]   w_end;
    logic                w_end_hit;
    logic [MINUTE_W:0]   w_timer_wall;
    logic [COUNT_W-1:0]  w_timer_sum;
    logic [COUNT_W-1:0]  w_timer;
    logic [MINUTE_W-1:0] w_wait_left;
    logic [COUNT_W-1:0]  w_wait_sat;
    logic [MINUTE_W-1:0] w_next_start;
    logic [COUNT_W-1:0]  w_mp_eff;
    logic [MINUTE_W-1:0] w_last_eff;
    t_run_state          w_st;
    logic [COUNT_W-1:0]  w_mag;
    logic                w_over;
    logic [RETRY_W-1:0]  w_retry_inc;
    logic                w_alarm;
    logic [COUNT_W-1:0]  w_mp_next;

    assign w_now = i_item.now_minute;

    // First start: after a delay, or at a minute of day (next day if passed)
    assign w_wrap_day   = COUNT_W'(i_day_rem) > i_cfg.delay_minutes;
    assign w_init_start = i_cfg.delay_mode
        ? MINUTE_W'(i_cfg.start_minute - MINUTE_W'(i_day_rem)
                    + MINUTE_W'(i_cfg.delay_minutes)
                    + (w_wrap_day ? MINUTE_W'(MIN_PER_DAY) : MINUTE_W'(0)))
        : MINUTE_W'(i_cfg.start_minute + MINUTE_W'(i_cfg.delay_minutes));

    // Loop step terms
    assign w_in_wait  = (r_phase == PH_WAIT);
    assign w_due      = (w_now >= r_start_time);
    assign w_quit     = i_item.clean_request || (r_loop > i_cfg.loop_count);
    assign w_mp_eff   = w_in_wait ? '0 : r_mp;
    assign w_last_eff = w_in_wait ? w_now : r_last;

    assign w_end        = {1'b0, r_start_time} + (MINUTE_W+1)'(i_cfg.sample_minutes);
    assign w_timer_wall = w_end - {1'b0, w_now};
    assign w_timer_sum  = i_cfg.sample_minutes - w_mp_eff;
    assign w_end_hit    = i_cfg.sample_mode ? (w_mp_eff >= i_cfg.sample_minutes)
                                            : ({1'b0, w_now} >= w_end);
    assign w_timer = i_cfg.sample_mode ? w_timer_sum
        : ((|w_timer_wall[MINUTE_W:COUNT_W]) ? '1 : w_timer_wall[COUNT_W-1:0]);

    assign w_wait_left = r_start_time - w_now;
    assign w_wait_sat  = (|w_wait_left[MINUTE_W-1:COUNT_W]) ? '1
                                                            : w_wait_left[COUNT_W-1:0];

    assign w_next_start = MINUTE_W'((i_cfg.sample_mode ? w_now : w_end[MINUTE_W-1:0])
                                    + MINUTE_W'(i_cfg.suspend_minutes));

    // Pump decision
    assign w_st = (i_item.fatal_request || r_fatal) ? ST_ERROR
                : (i_item.pause_request ? ST_PAUSE : ST_SAMPLE);

    // Pressure protection
    assign w_mag       = i_item.pressure[COUNT_W-1] ? COUNT_W'(~i_item.pressure + 1'b1)
                                                    : COUNT_W'(i_item.pressure);
    assign w_over      = (i_cfg.pressure_limit != '0) && !(w_mag < i_cfg.pressure_limit);
    assign w_retry_inc = r_retry + 1'b1;
    assign w_alarm     = w_over && (r_retry < RETRY_MAX)
                         && ((LOOP_W+1)'(w_retry_inc) > (LOOP_W+1)'(ALARM_AFTER));

    // Minute accounting
    assign w_mp_next = ((w_now != w_last_eff) && (w_st == ST_SAMPLE) && (w_mp_eff != '1))
                       ? w_mp_eff + 1'b1 : w_mp_eff;

    // Next state
    always_comb begin
        n_phase      = r_phase;
        n_start_time = r_start_time;
        n_loop       = r_loop;
        n_mp         = r_mp;
        n_retry      = r_retry;
        n_fatal      = r_fatal;
        n_last       = r_last;
        case (r_phase)
            PH_INIT: begin
                if (i_cfg.start_minute != '0) begin
                    n_start_time = w_init_start;
                    n_loop       = LOOP_W'(1);
                    n_phase      = PH_WAIT;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                if (w_quit) begin
                    n_phase = PH_DONE;
                end else if (w_in_wait && !w_due) begin
                    n_phase = PH_WAIT;
                end else if (w_end_hit) begin
                    n_start_time = w_next_start;
                    n_mp         = w_mp_eff;
                    n_last       = w_last_eff;
                    if (r_loop >= i_cfg.loop_count) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_loop  = r_loop + 1'b1;
                        n_phase = PH_WAIT;
                    end
                end else begin
                    n_phase = PH_SAMPLE;
                    n_mp    = w_mp_next;
                    n_last  = w_now;
                    if (w_over) begin
                        if (r_retry < RETRY_MAX) begin
                            n_retry = w_retry_inc;
                        end else begin
                            n_fatal = 1'b1;
                        end
                    end else if (i_cfg.pressure_limit != '0) begin
                        n_retry = '0;
                    end
                end
            end
        endcase
    end

    // Result of this step
    always_comb begin
        o_ret = 1'b0;
        o_res = '{pump_on: 1'b0, run_state: ST_FINISH, remaining_minutes: '0,
                  loop_number: '0, sampled_minutes: '0, alarm_beep: 1'b0};
        case (r_phase)
            PH_INIT: begin
                o_ret = (i_cfg.start_minute == '0);
            end
            PH_DONE: begin
                o_ret = 1'b1;
            end
            default: begin
                if (w_quit) begin
                    o_ret = 1'b1;
                end else if (w_in_wait && !w_due) begin
                    o_ret                   = 1'b1;
                    o_res.run_state         = i_item.pause_request ? ST_PAUSE : ST_SUSPEND;
                    o_res.remaining_minutes = w_wait_sat;
                    o_res.loop_number       = r_loop;
                end else if (w_end_hit) begin
                    o_ret = (r_loop >= i_cfg.loop_count);
                end else begin
                    o_ret                   = 1'b1;
                    o_res.pump_on           = (w_st == ST_SAMPLE);
                    o_res.run_state         = w_st;
                    o_res.remaining_minutes = w_timer;
                    o_res.loop_number       = r_loop;
                    o_res.sampled_minutes   = w_mp_next;
                    o_res.alarm_beep        = w_alarm;
                end
            end
        endcase
    end

    // Advance state on each step the top level lets through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_INIT;
            r_start_time <= '0;
            r_loop       <= '0;
            r_mp         <= '0;
            r_retry      <= '0;
            r_fatal      <= 1'b0;
            r_last       <= '0;
        end else if (i_go && i_valid) begin
            r_phase      <= n_phase;
            r_start_time <= n_start_time;
            r_loop       <= n_loop;
            r_mp         <= n_mp;
            r_retry      <= n_retry;
            r_fatal      <= n_fatal;
            r_last       <= n_last;
        end
    end

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |=> (r_phase == PH_DONE))
        else $error("finished task left the done phase");

    a_fatal_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fatal |=> r_fatal)
        else $error("fatal latch cleared without reset");

    a_retry_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_retry <= RETRY_MAX)
        else $error("retry count above its limit");

    a_loop_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_WAIT) || (r_phase == PH_SAMPLE)) |-> (r_loop != '0))
        else $error("run number zero while a task is active");

endmodule

`default_nettype wire

// ===== sv/timed_sampling_sequencer_top.sv =====
// Timed sampling sequencer, top level: config registers, input stage, output register.
// Result registered when the core step on the staged item returns with output room; the
// first tick also steps through initialize, and each run already due takes its own step.
// Throughput: one item per cycle, set by the one-step-per-cycle sequencer loop, when no
// extra step or stall intervenes; start_minute writes hold off input (minute-of-day unit).
// Reset: synchronous, active low; config to reset values, task restarts from initialize.
`default_nettype none

module timed_sampling_sequencer_top #(
    parameter int unsigned RETRY_LIMIT = 15
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic [tss_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire logic [tss_pkg::CFG_W-1:0]        i_cfg_wdata,
    // Poll tick stream
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // tdata, low bit up: now_minute[26:0], clean_request, pause_request,
    // fatal_request, pressure[15:0], zero pad
    input  wire logic [tss_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // Result stream
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // tdata, low bit up: pump_on, run_state[2:0], remaining_minutes[15:0],
    // loop_number[7:0], sampled_minutes[15:0], alarm_beep, zero pad
    output logic      [tss_pkg::OUT_DATA_W-1:0]   o_m_tdata
);
    import tss_pkg::*;

    t_cfg                r_cfg;
    logic                r_hold;
    logic                r_stg_valid;
    t_item               r_stg;
    logic                r_out_valid;
    t_result             r_out;

    logic [DAYREM_W-1:0] w_day_rem;
    logic                w_core_ret;
    t_result             w_core_res;
    logic                w_out_free;
    logic                w_go;
    logic                w_consume;
    logic                w_start_wr;
    logic                w_s_fire;
    t_item               w_in_item;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{start_minute: '0, delay_minutes: '0, delay_mode: 1'b1,
                       sample_minutes: '0, suspend_minutes: '0, loop_count: LOOP_W'(1),
                       sample_mode: 1'b0, pressure_limit: '0};
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_START_MINUTE:    r_cfg.start_minute    <= i_cfg_wdata[MINUTE_W-1:0];
                CFG_DELAY_MINUTES:   r_cfg.delay_minutes   <= i_cfg_wdata[COUNT_W-1:0];
                CFG_DELAY_MODE:      r_cfg.delay_mode      <= i_cfg_wdata[0];
                CFG_SAMPLE_MINUTES:  r_cfg.sample_minutes  <= i_cfg_wdata[COUNT_W-1:0];
                CFG_SUSPEND_MINUTES: r_cfg.suspend_minutes <= i_cfg_wdata[COUNT_W-1:0];
                CFG_LOOP_COUNT:      r_cfg.loop_count      <= i_cfg_wdata[LOOP_W-1:0];
                CFG_SAMPLE_MODE:     r_cfg.sample_mode     <= i_cfg_wdata[0];
                CFG_PRESSURE_LIMIT:  r_cfg.pressure_limit  <= i_cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold off input while the minute-of-day unit catches up with a new start
    assign w_start_wr = i_cfg_we && (t_cfg_idx'(i_cfg_addr) == CFG_START_MINUTE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
        end else begin
            r_hold <= w_start_wr;
        end
    end

    tss_day_rem u_day_rem (
        .i_clk     (i_clk),
        .i_minute  (r_cfg.start_minute),
        .o_day_rem (w_day_rem)
    );

    tss_core #(
        .RETRY_LIMIT (RETRY_LIMIT)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_day_rem (w_day_rem),
        .i_item    (r_stg),
        .i_valid   (r_stg_valid),
        .i_go      (w_go),
        .o_ret     (w_core_ret),
        .o_res     (w_core_res)
    );

    // Step control: a returning step needs room in the output register
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_go       = r_stg_valid && (!w_core_ret || w_out_free);
    assign w_consume  = w_go && w_core_ret;
    assign o_s_tready = (!r_stg_valid || w_consume) && !r_hold && !w_start_wr;
    assign w_s_fire   = i_s_tvalid && o_s_tready;

    // Unpack the input item
    assign w_in_item.now_minute    = i_s_tdata[26:0];
    assign w_in_item.clean_request = i_s_tdata[27];
    assign w_in_item.pause_request = i_s_tdata[28];
    assign w_in_item.fatal_request = i_s_tdata[29];
    assign w_in_item.pressure      = i_s_tdata[45:30];

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
        end else if (w_s_fire) begin
            r_stg_valid <= 1'b1;
        end else if (w_consume) begin
            r_stg_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_stg <= w_in_item;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_consume) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_consume) begin
            r_out <= w_core_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out.alarm_beep, r_out.sampled_minutes,
                         r_out.loop_number, r_out.remaining_minutes,
                         r_out.run_state, r_out.pump_on};

endmodule

`default_nettype wire
